// ----- rtl/core/extended_state_observer_macros.svh -----
// extended_state_observer_macros.svh: assertion macros shared by the observer RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef EXTENDED_STATE_OBSERVER_MACROS_SVH
`define EXTENDED_STATE_OBSERVER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ESO_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("observer check failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ESO_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("observer check failed: next-cycle implication");

`endif

// ----- rtl/core/eso_pkg.sv -----
`timescale 1ns / 1ps
// eso_pkg.sv: widths, types, register indexes and reset values of the observer.
// No dependencies; imported by every observer module.
package eso_pkg;

    localparam int QW   = 48;  // Q24.24 word
    localparam int GW   = 47;  // unsigned gain and limit width
    localparam int DTW  = 25;  // sample period width
    localparam int FRAC = 24;  // fraction bits
    localparam int IDXW = 3;   // configuration index width
    localparam int MCW  = $clog2(QW);  // multiplier bit counter

    typedef logic signed [QW-1:0] q_t;

    localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

    localparam logic [IDXW-1:0] REG_GAIN_POSITION    = 3'd0;
    localparam logic [IDXW-1:0] REG_GAIN_RATE        = 3'd1;
    localparam logic [IDXW-1:0] REG_GAIN_DISTURBANCE = 3'd2;
    localparam logic [IDXW-1:0] REG_INPUT_GAIN       = 3'd3;
    localparam logic [IDXW-1:0] REG_SAMPLE_PERIOD    = 3'd4;
    localparam logic [IDXW-1:0] REG_ERROR_LIMIT      = 3'd5;
    localparam logic [IDXW-1:0] REG_CLAMP_ENABLE     = 3'd6;

    typedef struct packed {
        logic [GW-1:0]  gain_position;
        logic [GW-1:0]  gain_rate;
        logic [GW-1:0]  gain_disturbance;
        q_t             input_gain;
        logic [DTW-1:0] sample_period;
        logic [GW-1:0]  error_limit;
        logic           clamp_enable;
    } eso_cfg_t;

    localparam eso_cfg_t CFG_RESET = '{
        gain_position:    47'd2013265920,
        gain_rate:        47'd80530636800,
        gain_disturbance: 47'd1073741824000,
        input_gain:       -48'sd1509949440,
        sample_period:    25'd16777,
        error_limit:      47'd1677722,
        clamp_enable:     1'b1
    };

    typedef struct packed {
        logic start;
        q_t   a;
        q_t   b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        q_t   product;
    } mul_rsp_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_sts_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_RUN,
        MS_ROUND,
        MS_SIGN
    } mul_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_LAUNCH,
        ST_WAIT,
        ST_SUM,
        ST_UPD,
        ST_OUT
    } core_state_t;

    // Products in the order the sequencer computes them.
    typedef enum logic [2:0] {
        OP_GP,
        OP_GR,
        OP_GD,
        OP_IG,
        OP_DP,
        OP_DR,
        OP_DD
    } op_t;

endpackage

// ----- rtl/core/eso_cfg.sv -----
`timescale 1ns / 1ps
// eso_cfg.sv: configuration register file of the observer.
// Depends on eso_pkg for the register indexes and reset values.
module eso_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic [eso_pkg::IDXW-1:0]  wr_index,
    input  eso_pkg::q_t               wr_data,
    output eso_pkg::eso_cfg_t         cfg
);
    import eso_pkg::*;

    eso_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_GAIN_POSITION:    cfg_next.gain_position    = wr_data[GW-1:0];
                REG_GAIN_RATE:        cfg_next.gain_rate        = wr_data[GW-1:0];
                REG_GAIN_DISTURBANCE: cfg_next.gain_disturbance = wr_data[GW-1:0];
                REG_INPUT_GAIN:       cfg_next.input_gain       = wr_data;
                REG_SAMPLE_PERIOD:    cfg_next.sample_period    = wr_data[DTW-1:0];
                REG_ERROR_LIMIT:      cfg_next.error_limit      = wr_data[GW-1:0];
                REG_CLAMP_ENABLE:     cfg_next.clamp_enable     = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/eso_mul.sv -----
`timescale 1ns / 1ps
// eso_mul.sv: bit-serial Q24.24 multiplier, one multiplier bit per cycle,
// round half away from zero and saturation. Depends on eso_pkg and the macro header.
`include "extended_state_observer_macros.svh"

module eso_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  eso_pkg::mul_req_t req,
    output eso_pkg::mul_rsp_t rsp
);
    import eso_pkg::*;

    localparam int PW = 2 * QW;
    localparam int RW = PW - FRAC;

    mul_state_t     state_reg, state_next;
    logic [MCW-1:0] cnt_reg, cnt_next;
    logic           neg_reg, neg_next;
    logic [QW-1:0]  mcand_reg, mcand_next;
    logic [PW-1:0]  acc_reg, acc_next;
    q_t             res_reg, res_next;
    logic           done_reg, done_next;

    logic [QW-1:0]  mag_a, mag_b;
    logic [QW:0]    partial;
    logic [RW-1:0]  rounded;
    logic           big;

    // Magnitudes; the most negative value maps onto 2^47, which fits unsigned.
    assign mag_a = req.a[QW-1] ? QW'(~req.a + 1'b1) : QW'(req.a);
    assign mag_b = req.b[QW-1] ? QW'(~req.b + 1'b1) : QW'(req.b);

    assign partial = {1'b0, acc_reg[PW-1:QW]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
    assign rounded = acc_reg[PW-1:FRAC] + {{(RW-1){1'b0}}, acc_reg[FRAC-1]};
    assign big     = |acc_reg[RW-1:QW-1];

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MS_IDLE: begin
                if (req.start) begin
                    neg_next   = req.a[QW-1] ^ req.b[QW-1];
                    mcand_next = mag_a;
                    acc_next   = {{QW{1'b0}}, mag_b};
                    cnt_next   = '0;
                    state_next = MS_RUN;
                end
            end
            MS_RUN: begin
                acc_next = {partial, acc_reg[QW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MCW'(QW - 1)) begin
                    state_next = MS_ROUND;
                end
            end
            MS_ROUND: begin
                acc_next   = {{FRAC{1'b0}}, rounded};
                state_next = MS_SIGN;
            end
            MS_SIGN: begin
                if (neg_reg) begin
                    res_next = big ? Q_MIN : q_t'(~acc_reg[QW-1:0] + 1'b1);
                end else begin
                    res_next = big ? Q_MAX : q_t'(acc_reg[QW-1:0]);
                end
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        res_reg   <= res_next;
    end

    assign rsp.busy    = (state_reg != MS_IDLE);
    assign rsp.done    = done_reg;
    assign rsp.product = res_reg;

    `ESO_ASSERT_IMP(a_mul_start_idle, aclk, aresetn, req.start, state_reg == MS_IDLE)
    `ESO_ASSERT_NXT(a_mul_done_pulse, aclk, aresetn, done_reg, !done_reg && !rsp.busy)

endmodule

// ----- rtl/core/eso_core.sv -----
`timescale 1ns / 1ps
// eso_core.sv: observer sequencer and estimate datapath around the serial multiplier.
// Depends on eso_pkg and eso_mul.
module eso_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  eso_pkg::q_t         meas,
    input  eso_pkg::q_t         control,
    input  eso_pkg::q_t         feed,
    input  eso_pkg::eso_cfg_t   cfg,
    input  logic                out_free,
    output eso_pkg::core_sts_t  sts,
    output eso_pkg::q_t         est_position,
    output eso_pkg::q_t         est_rate,
    output eso_pkg::q_t         est_disturbance
);
    import eso_pkg::*;

    localparam int NPROD = 7;

    function automatic logic [QW+1:0] ext2(input q_t x);
        return {{2{x[QW-1]}}, x};
    endfunction

    function automatic q_t sat_q(input logic [QW+1:0] v);
        q_t res;
        if (v[QW+1:QW-1] == 3'b000 || v[QW+1:QW-1] == 3'b111) begin
            res = q_t'(v[QW-1:0]);
        end else if (v[QW+1]) begin
            res = Q_MIN;
        end else begin
            res = Q_MAX;
        end
        return res;
    endfunction

    core_state_t state_reg, state_next;
    op_t         op_reg, op_next;
    logic        started_reg, started_next;
    logic        first_reg, first_next;
    q_t          p_reg, p_next;
    q_t          r_reg, r_next;
    q_t          d_reg, d_next;
    q_t          e_reg, e_next;
    q_t          t0_reg, t0_next;
    q_t          t1_reg, t1_next;
    q_t          t2_reg, t2_next;
    q_t          prod_reg [NPROD];
    q_t          prod_next [NPROD];

    mul_req_t    mreq;
    mul_rsp_t    mrsp;

    q_t               p_eff;
    logic signed [QW:0] diff, lim, neg_lim;
    q_t               e_calc;
    q_t               dt_q;

    eso_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    // Tracking error against the position estimate in force for this sample.
    always_comb begin
        p_eff   = started_reg ? p_reg : meas;
        diff    = $signed({meas[QW-1], meas}) - $signed({p_eff[QW-1], p_eff});
        lim     = $signed({2'b00, cfg.error_limit});
        neg_lim = -lim;
        if (cfg.clamp_enable) begin
            if (diff > lim) begin
                e_calc = q_t'(lim[QW-1:0]);
            end else if (diff < neg_lim) begin
                e_calc = q_t'(neg_lim[QW-1:0]);
            end else begin
                e_calc = q_t'(diff[QW-1:0]);
            end
        end else begin
            e_calc = sat_q({diff[QW], diff});
        end
    end

    assign dt_q = q_t'({{(QW-DTW){1'b0}}, cfg.sample_period});

    always_comb begin
        mreq.start = (state_reg == ST_LAUNCH);
        case (op_reg)
            OP_GP: begin
                mreq.a = q_t'({1'b0, cfg.gain_position});
                mreq.b = e_reg;
            end
            OP_GR: begin
                mreq.a = q_t'({1'b0, cfg.gain_rate});
                mreq.b = e_reg;
            end
            OP_GD: begin
                mreq.a = q_t'({1'b0, cfg.gain_disturbance});
                mreq.b = e_reg;
            end
            OP_IG: begin
                mreq.a = cfg.input_gain;
                mreq.b = first_reg ? '0 : control;
            end
            OP_DP: begin
                mreq.a = dt_q;
                mreq.b = t0_reg;
            end
            OP_DR: begin
                mreq.a = dt_q;
                mreq.b = t1_reg;
            end
            OP_DD: begin
                mreq.a = dt_q;
                mreq.b = t2_reg;
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        started_next = started_reg;
        first_next   = first_reg;
        p_next       = p_reg;
        r_next       = r_reg;
        d_next       = d_reg;
        e_next       = e_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        prod_next    = prod_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                // The first sample seeds the position from the measurement.
                if (!started_reg) begin
                    p_next       = meas;
                    r_next       = '0;
                    d_next       = '0;
                    started_next = 1'b1;
                    first_next   = 1'b1;
                end else begin
                    first_next   = 1'b0;
                end
                e_next     = e_calc;
                op_next    = OP_GP;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mrsp.done) begin
                    prod_next[op_reg] = mrsp.product;
                    if (op_reg == OP_IG) begin
                        op_next    = OP_DP;
                        state_next = ST_SUM;
                    end else if (op_reg == OP_DD) begin
                        state_next = ST_UPD;
                    end else begin
                        op_next    = op_t'(op_reg + 1'b1);
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_SUM: begin
                t0_next    = sat_q(ext2(r_reg) + ext2(prod_reg[OP_GP]));
                t1_next    = sat_q(ext2(d_reg) + ext2(prod_reg[OP_GR]) + ext2(prod_reg[OP_IG]));
                t2_next    = sat_q(ext2(prod_reg[OP_GD]) + ext2(feed));
                state_next = ST_LAUNCH;
            end
            ST_UPD: begin
                p_next     = sat_q(ext2(p_reg) + ext2(prod_reg[OP_DP]));
                r_next     = sat_q(ext2(r_reg) + ext2(prod_reg[OP_DR]));
                d_next     = sat_q(ext2(d_reg) + ext2(prod_reg[OP_DD]));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_GP;
            started_reg <= 1'b0;
            first_reg   <= 1'b0;
            p_reg       <= '0;
            r_reg       <= '0;
            d_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            started_reg <= started_next;
            first_reg   <= first_next;
            p_reg       <= p_next;
            r_reg       <= r_next;
            d_reg       <= d_next;
        end
        e_reg    <= e_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        prod_reg <= prod_next;
    end

    assign sts.idle        = (state_reg == ST_IDLE);
    assign sts.res_valid   = (state_reg == ST_OUT);
    assign est_position    = p_reg;
    assign est_rate        = r_reg;
    assign est_disturbance = d_reg;

endmodule

// ----- rtl/core/extended_state_observer.sv -----
`timescale 1ns / 1ps
// An accepted input beat runs through seven products on the one shared bit-serial
// multiplier, each made of shift-add iterations over the multiplier bits plus round,
// sign and hand-back; the next input beat is taken only once the result has moved into
// the output register, so a stalled output side holds the input back.
// Reset (aresetn, synchronous, active low) restores the register defaults and clears
// the estimates, the first-sample flag and both channels; no clearing pass is needed.
`include "extended_state_observer_macros.svh"

// Third-order linear extended state observer.
//
// Each input beat carries a measured position, the applied control and a rate feed
// term. The block keeps estimates of position, rate and total disturbance and returns
// the three updated estimates as one output beat. All quantities are signed Q24.24 in
// 48 bits and every estimate saturates.
//
// The very first beat after reset seeds the position estimate from the measurement,
// zeroes the rate and disturbance estimates and treats the control as zero; the
// normal update then runs on top of that, so the rate feed already acts.
//
// The input beat is held in registers for the whole update and the result sits in its
// own output register, so a finished beat may wait on m_ready while the next input
// beat is accepted. Configuration writes go straight into the register file and are
// always accepted; they are expected only while the observer is idle.
module extended_state_observer (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  eso_pkg::q_t              s_measurement,
    input  eso_pkg::q_t              s_control,
    input  eso_pkg::q_t              s_rate_feed,

    output logic                     m_valid,
    input  logic                     m_ready,
    output eso_pkg::q_t              m_est_position,
    output eso_pkg::q_t              m_est_rate,
    output eso_pkg::q_t              m_est_disturbance,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [eso_pkg::IDXW-1:0] cfg_index,
    input  eso_pkg::q_t              cfg_data
);
    import eso_pkg::*;

    // Input holding registers: the item stays here until its result has been
    // moved into the output register.
    logic      in_full_reg, in_full_next;
    q_t        meas_reg, meas_next;
    q_t        ctrl_reg, ctrl_next;
    q_t        feed_reg, feed_next;

    // Output register.
    logic      m_valid_reg, m_valid_next;
    q_t        m_pos_reg, m_pos_next;
    q_t        m_rate_reg, m_rate_next;
    q_t        m_dist_reg, m_dist_next;

    logic      s_accept;
    logic      out_free;
    logic      out_load;
    eso_cfg_t  cfg;
    core_sts_t sts;
    q_t        est_pos, est_rate, est_dist;

    assign s_ready   = !in_full_reg;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // The output register can take a result when it is empty or being emptied.
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = sts.res_valid && out_free;

    eso_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    eso_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .start           (s_accept),
        .meas            (meas_reg),
        .control         (ctrl_reg),
        .feed            (feed_reg),
        .cfg             (cfg),
        .out_free        (out_free),
        .sts             (sts),
        .est_position    (est_pos),
        .est_rate        (est_rate),
        .est_disturbance (est_dist)
    );

    always_comb begin
        in_full_next = in_full_reg;
        meas_next    = meas_reg;
        ctrl_next    = ctrl_reg;
        feed_next    = feed_reg;
        if (s_accept) begin
            in_full_next = 1'b1;
            meas_next    = s_measurement;
            ctrl_next    = s_control;
            feed_next    = s_rate_feed;
        end else if (out_load) begin
            in_full_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pos_next   = m_pos_reg;
        m_rate_next  = m_rate_reg;
        m_dist_next  = m_dist_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_pos_next   = est_pos;
            m_rate_next  = est_rate;
            m_dist_next  = est_dist;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_full_reg <= in_full_next;
            m_valid_reg <= m_valid_next;
        end
        meas_reg   <= meas_next;
        ctrl_reg   <= ctrl_next;
        feed_reg   <= feed_next;
        m_pos_reg  <= m_pos_next;
        m_rate_reg <= m_rate_next;
        m_dist_reg <= m_dist_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_est_position    = m_pos_reg;
    assign m_est_rate        = m_rate_reg;
    assign m_est_disturbance = m_dist_reg;

    // A finished result always belongs to the item still held at the input.
    `ESO_ASSERT_IMP(a_res_has_item, aclk, aresetn, sts.res_valid, in_full_reg)
    // A new input beat is only taken while the sequencer is idle.
    `ESO_ASSERT_IMP(a_accept_core_idle, aclk, aresetn, s_accept, sts.idle)
    // Moving a result out fills the output register and frees the input side.
    `ESO_ASSERT_NXT(a_load_frees_input, aclk, aresetn, out_load, m_valid_reg && !in_full_reg)

endmodule
